// ===== rtl/ddtoi_pkg.sv =====
// Package for the disc-disc time of impact core: shared widths, types and helpers.
// Depends on nothing; used by the top level, ddtoi_setup and ddtoi_cell.
package ddtoi_pkg;

  localparam int CoordBits     = 24;
  localparam int TimeFracBits  = 16;
  localparam int DiffBits      = CoordBits + 2;          // d and e components
  localparam int ProdBits      = 2 * DiffBits + 2;       // a, b, c
  localparam int TimeBits      = TimeFracBits + 1;
  localparam int StepBits      = TimeFracBits + 1;       // bits of k, one per cell
  // f(t) scaled by s^2 and its slope scaled by s need coef + 2*TimeBits plus headroom.
  localparam int ScaledBits    = ProdBits + 2 * TimeBits + 4;

  typedef logic signed [ProdBits-1:0]   coef_t;
  typedef logic signed [ScaledBits-1:0] scaled_t;

  typedef struct packed {
    logic            valid;
    logic            search;   // quadratic case, bisection still running
    logic            hit;
    logic [TimeBits-1:0] k;
    coef_t           a;
    scaled_t         f;        // a k^2 + b k s + c s^2 at the current k
    scaled_t         slope;    // 2 a k + b s at the current k
  } cell_word_t;

endpackage

// ===== rtl/disc_disc_time_of_impact_core.sv =====
// Top level of the disc-disc time of impact core.
// Depends on ddtoi_pkg, ddtoi_setup and ddtoi_cell.
//
//   channel | handshake        | words
//   input   | start / busy     | two discs: start, end, radius each
//   result  | done (strobe)    | hit, impact_time
//
// One pair per cycle enters; busy is held low. The pipeline is four setup stages
// (differences, coefficients, partial products, discriminant), then one bisection
// cell per time bit, then the result register.
// Reset is synchronous and clears all valid bits in the chain.
// The receiver cannot stall; each result is shown for exactly one cycle on done.
module disc_disc_time_of_impact_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [23:0] a_start_x,
  input  logic [23:0] a_start_y,
  input  logic [23:0] a_end_x,
  input  logic [23:0] a_end_y,
  input  logic [22:0] a_radius,
  input  logic [23:0] b_start_x,
  input  logic [23:0] b_start_y,
  input  logic [23:0] b_end_x,
  input  logic [23:0] b_end_y,
  input  logic [22:0] b_radius,
  output logic        done,
  output logic        hit,
  output logic [16:0] impact_time
);

  localparam int NC = ddtoi_pkg::StepBits;

  ddtoi_pkg::cell_word_t chain [NC+1];

  // The chain never stalls, so a new word is always welcome.
  assign busy = 1'b0;

  ddtoi_setup u_setup (
    .clk(clk), .rst(rst), .take(start && !busy),
    .ax0(a_start_x), .ay0(a_start_y), .ax1(a_end_x), .ay1(a_end_y), .ra(a_radius),
    .bx0(b_start_x), .by0(b_start_y), .bx1(b_end_x), .by1(b_end_y), .rb(b_radius),
    .word_out(chain[0])
  );

  // Cell i decides time bit NC-1-i, most significant first, as a binary search.
  for (genvar i = 0; i < NC; i++) begin : g_cell
    ddtoi_cell #(.BIT(NC - 1 - i)) u_cell (
      .clk(clk), .rst(rst), .word_in(chain[i]), .word_out(chain[i+1])
    );
  end

  always_ff @(posedge clk) begin
    hit         <= chain[NC].hit;
    impact_time <= chain[NC].hit ? chain[NC].k : '0;
    done        <= rst ? 1'b0 : chain[NC].valid;
  end

endmodule

// ===== rtl/ddtoi_cell.sv =====
// One bisection cell: tries one bit of the contact time and passes the word on.
// Depends on ddtoi_pkg.
module ddtoi_cell #(
  parameter int BIT = 0
) (
  input  logic                   clk,
  input  logic                   rst,
  input  ddtoi_pkg::cell_word_t  word_in,
  output ddtoi_pkg::cell_word_t  word_out
);

  localparam int TB = ddtoi_pkg::TimeBits;
  localparam int FB = ddtoi_pkg::TimeFracBits;
  localparam int SB = ddtoi_pkg::ScaledBits;

  logic [TB-1:0]           trial;
  ddtoi_pkg::scaled_t      a_ext;
  ddtoi_pkg::scaled_t      slope_try;
  ddtoi_pkg::scaled_t      f_try;
  logic                    take;
  ddtoi_pkg::cell_word_t   word;

  // Bit BIT of k is still clear, so the trial is k + d with d = 2^BIT. Then
  // slope(k + d) = slope(k) + 2 a d and f(k + d) = f(k) + d slope(k) + a d^2,
  // which are shifts and adds only.
  always_comb begin
    trial     = word_in.k | (TB'(1) << BIT);
    a_ext     = SB'(word_in.a);
    slope_try = word_in.slope + (a_ext <<< (BIT + 1));
    f_try     = word_in.f + (word_in.slope <<< BIT) + (a_ext <<< (2 * BIT));
    take      = word_in.search && (trial <= TB'(1 << FB))
              && !(slope_try > 0) && !f_try[SB-1];
    word      = word_in;
    if (take) begin
      word.k     = trial;
      word.f     = f_try;
      word.slope = slope_try;
    end
  end

  always_ff @(posedge clk) begin
    word_out <= word;
    if (rst) begin
      word_out.valid <= 1'b0;
    end
  end

endmodule

// ===== rtl/ddtoi_setup.sv =====
// Front end: forms the quadratic coefficients and decides the case of each pair.
// Depends on ddtoi_pkg.
module ddtoi_setup (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          take,
  input  logic signed [ddtoi_pkg::CoordBits-1:0] ax0, ay0, ax1, ay1,
  input  logic [ddtoi_pkg::CoordBits-2:0]        ra,
  input  logic signed [ddtoi_pkg::CoordBits-1:0] bx0, by0, bx1, by1,
  input  logic [ddtoi_pkg::CoordBits-2:0]        rb,
  output ddtoi_pkg::cell_word_t         word_out
);

  localparam int DB = ddtoi_pkg::DiffBits;
  localparam int PB = ddtoi_pkg::ProdBits;
  localparam int SB = ddtoi_pkg::ScaledBits;
  localparam int FB = ddtoi_pkg::TimeFracBits;
  localparam int HB = PB / 2;          // split point of the wide products
  localparam int MB = 2 * HB + 2;      // width of one partial product
  localparam int QB = 2 * PB + 4;

  logic signed [DB-1:0] dx, dy, ex, ey, rs;
  logic                 v1, v2, v3;
  ddtoi_pkg::coef_t     a, b, c;
  ddtoi_pkg::coef_t     a3, b3, c3;
  logic                 behind, ahead, azero;
  logic signed [HB:0]   ah, al, bh, bl, ch, cl;
  logic signed [MB-1:0] bb_hh, bb_hl, bb_ll, ac_hh, ac_hl, ac_lh, ac_ll;
  logic signed [QB-1:0] disc;
  ddtoi_pkg::cell_word_t word;

  // Halves of the coefficients, so the discriminant needs only narrow multipliers.
  always_comb begin
    ah = (HB+1)'(signed'(a[PB-1:HB]));
    al = signed'({1'b0, a[HB-1:0]});
    bh = (HB+1)'(signed'(b[PB-1:HB]));
    bl = signed'({1'b0, b[HB-1:0]});
    ch = (HB+1)'(signed'(c[PB-1:HB]));
    cl = signed'({1'b0, c[HB-1:0]});
  end

  // Stage one registers the differences, stage two the coefficients, stage three
  // the case flags and the partial products of b^2 and a*c.
  always_ff @(posedge clk) begin
    dx <= DB'(ax0) - DB'(bx0);
    dy <= DB'(ay0) - DB'(by0);
    ex <= (DB'(ax1) - DB'(bx1)) - (DB'(ax0) - DB'(bx0));
    ey <= (DB'(ay1) - DB'(by1)) - (DB'(ay0) - DB'(by0));
    rs <= DB'(signed'({1'b0, ra})) + DB'(signed'({1'b0, rb}));
    v1 <= rst ? 1'b0 : take;

    a  <= PB'(ex) * PB'(ex) + PB'(ey) * PB'(ey);
    b  <= (PB'(dx) * PB'(ex) + PB'(dy) * PB'(ey)) <<< 1;
    c  <= PB'(dx) * PB'(dx) + PB'(dy) * PB'(dy) - PB'(rs) * PB'(rs);
    v2 <= rst ? 1'b0 : v1;

    a3     <= a;
    b3     <= b;
    c3     <= c;
    azero  <= (a == '0);
    behind <= (b > 0) && (c > 0);
    ahead  <= (((a <<< 1) + b) < 0) && ((a + b + c) > 0);
    bb_hh  <= MB'(bh) * MB'(bh);
    bb_hl  <= MB'(bh) * MB'(bl);
    bb_ll  <= MB'(bl) * MB'(bl);
    ac_hh  <= MB'(ah) * MB'(ch);
    ac_hl  <= MB'(ah) * MB'(cl);
    ac_lh  <= MB'(al) * MB'(ch);
    ac_ll  <= MB'(al) * MB'(cl);
    v3     <= rst ? 1'b0 : v2;
  end

  // Stage four sums the partial products into b^2 - 4ac and seeds the bisection
  // with f(0) = c s^2 and slope(0) = b s.
  always_comb begin
    disc = (QB'(bb_hh) <<< (2 * HB)) + (QB'(bb_hl) <<< (HB + 1)) + QB'(bb_ll)
         - (((QB'(ac_hh) <<< (2 * HB)) + ((QB'(ac_hl) + QB'(ac_lh)) <<< HB)
             + QB'(ac_ll)) <<< 2);
    word.valid = v3;
    word.a     = a3;
    word.f     = SB'(c3) <<< (2 * FB);
    word.slope = SB'(b3) <<< FB;
    word.k     = '0;
    if (azero) begin
      word.search = 1'b0;
      word.hit    = !(c3 > 0);
    end else begin
      word.hit    = !disc[QB-1] && !behind && !ahead;
      word.search = word.hit;
    end
  end

  always_ff @(posedge clk) begin
    word_out <= word;
    if (rst) begin
      word_out.valid <= 1'b0;
    end
  end

endmodule

// ===== rtl/ddtoi_checker.sv =====
// Port-level checker for the disc-disc time of impact core, bound to the top level.
// Depends on disc_disc_time_of_impact_core.
module ddtoi_checker (
  input logic        clk,
  input logic        rst,
  input logic        start,
  input logic        busy,
  input logic        done,
  input logic        hit,
  input logic [16:0] impact_time
);

  a_time_range: assert property (@(posedge clk) disable iff (rst)
    done |-> impact_time <= 17'd65536) else $error("impact_time above 1.0");
  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    done && !hit |-> impact_time == 17'd0) else $error("time nonzero on miss");
  a_latency: assert property (@(posedge clk) disable iff (rst)
    start && !busy |-> ##22 done) else $error("result missing after latency");
  a_no_busy: assert property (@(posedge clk) disable iff (rst)
    !busy) else $error("core stalled");

endmodule

bind disc_disc_time_of_impact_core ddtoi_checker u_checker (
  .clk(clk), .rst(rst), .start(start), .busy(busy),
  .done(done), .hit(hit), .impact_time(impact_time)
);

// ===== test/tb_disc_disc_time_of_impact_core.sv =====
// Testbench for the disc-disc time of impact core: directed and random disc pairs,
// predicted by an exact integer model of the contact quadratic and checked per word.
// Depends on rtl/ddtoi_pkg.sv and rtl/disc_disc_time_of_impact_core.sv.
`timescale 1ns / 1ps

// One input word: two discs, each with start centre, end centre and radius.
typedef struct {
  logic signed [23:0] ax0, ay0, ax1, ay1;
  logic        [22:0] ra;
  logic signed [23:0] bx0, by0, bx1, by1;
  logic        [22:0] rb;
} disc_pair_t;

typedef struct {
  logic        hit;
  logic [16:0] t;
} contact_t;

class contact_scoreboard;
  contact_t pending[$];
  int errors;

  // Is k / 2^16 at or before the earlier root? Valid for a > 0 with real roots.
  static function bit before_first_root(logic signed [191:0] a, logic signed [191:0] b,
                                        logic signed [191:0] c, int k);
    logic signed [191:0] wk, s, slope, f;
    wk = k;
    s = 192'sd65536;
    slope = 2 * a * wk + b * s;
    f = a * wk * wk + b * wk * s + c * s * s;
    if (slope > 0) return 0;
    return f >= 0;
  endfunction

  static function contact_t predict_contact(disc_pair_t p);
    logic signed [191:0] dx, dy, ex, ey, rs, a, b, c, disc, slope1, f1;
    contact_t r;
    int k, tr;
    dx = p.ax0 - p.bx0;  // operands sign-extended to 192 bits by context
    dy = p.ay0 - p.by0;
    ex = (192'(p.ax1) - 192'(p.bx1)) - dx;
    ey = (192'(p.ay1) - 192'(p.by1)) - dy;
    rs = $signed({1'b0, p.ra}) + $signed({1'b0, p.rb});
    c = dx * dx + dy * dy - rs * rs;
    b = 2 * (dx * ex + dy * ey);
    a = ex * ex + ey * ey;
    r.hit = 0;
    r.t = '0;
    if (a == 0) begin
      r.hit = (c <= 0);
    end else begin
      disc = b * b - 4 * a * c;
      slope1 = 2 * a + b;
      f1 = a + b + c;
      if (disc >= 0 && !(b > 0 && c > 0) && !(slope1 < 0 && f1 > 0)) begin
        r.hit = 1;
        k = 0;
        for (int bitn = 16; bitn >= 0; bitn--) begin
          tr = k | (1 << bitn);
          if (tr <= 65536 && before_first_root(a, b, c, tr)) k = tr;
        end
        r.t = k[16:0];
      end
    end
    return r;
  endfunction

  function void note_pair(disc_pair_t p);
    pending.push_back(predict_contact(p));
  endfunction

  function void check_contact(logic hit, logic [16:0] t);
    contact_t e;
    if (pending.size() == 0) begin
      $error("unexpected result word: hit=%0d impact_time=%0d", hit, t);
      errors++;
      return;
    end
    e = pending.pop_front();
    if (hit !== e.hit) begin
      $error("hit: expected %0d, actual %0d", e.hit, hit);
      errors++;
    end
    if (t !== e.t) begin
      $error("impact_time: expected %0d, actual %0d", e.t, t);
      errors++;
    end
  endfunction
endclass

module tb_disc_disc_time_of_impact_core;
  localparam int Latency = 4 + ddtoi_pkg::StepBits + 1;
  localparam int WatchdogLimit = 2000;
  localparam int RandomPairs = 1850;

  logic clk = 0, rst = 1, start = 0;
  logic busy, done, hit;
  logic [16:0] impact_time;
  logic [23:0] a_start_x = 0, a_start_y = 0, a_end_x = 0, a_end_y = 0;
  logic [23:0] b_start_x = 0, b_start_y = 0, b_end_x = 0, b_end_y = 0;
  logic [22:0] a_radius = 0, b_radius = 0;

  contact_scoreboard sb = new();
  int idle_cycles = 0;
  bit quiet_stretch = 0;  // when set, the sender never pauses

  disc_disc_time_of_impact_core uut (.*);

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  // Results cannot be held off, so they are checked on every edge that sees done.
  always @(posedge clk) begin
    if (!rst && done) sb.check_contact(hit, impact_time);
  end

  // The watchdog counts cycles with no accepted word on either side.
  always @(posedge clk) begin
    if (rst || done || (start && !busy)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchdogLimit) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Drives one word and holds it until the core takes it. Start stays high
  // between back-to-back words; it only drops when the sender pauses or drains.
  task automatic send_pair(disc_pair_t p);
    if (!quiet_stretch) begin
      while ($urandom_range(99) < 18) begin
        start <= 0;
        @(posedge clk);
      end
    end
    start <= 1;
    a_start_x <= p.ax0; a_start_y <= p.ay0; a_end_x <= p.ax1; a_end_y <= p.ay1;
    a_radius <= p.ra;
    b_start_x <= p.bx0; b_start_y <= p.by0; b_end_x <= p.bx1; b_end_y <= p.by1;
    b_radius <= p.rb;
    do @(posedge clk); while (busy);
    sb.note_pair(p);
  endtask

  task automatic drain();
    start <= 0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
  endtask

  function automatic logic [23:0] rnd_coord(int span);
    case ($urandom_range(3))
      0: return 24'($urandom);
      1: return 24'($signed($urandom_range(2 * span)) - span);
      2: return $urandom_range(1) ? 24'h7FFFFF : 24'h800000;
      default: return 24'($signed($urandom_range(2000)) - 1000);
    endcase
  endfunction

  // Mostly pairs that approach each other so that real contacts and times appear.
  function automatic disc_pair_t random_pair();
    disc_pair_t p;
    int span;
    span = 1 << $urandom_range(8, 23);
    if (span > 8388607) span = 8388607;
    p.ax0 = rnd_coord(span); p.ay0 = rnd_coord(span);
    p.bx0 = rnd_coord(span); p.by0 = rnd_coord(span);
    if ($urandom_range(99) < 60) begin
      p.ax1 = p.bx0 + 24'($signed($urandom_range(span / 8)) - span / 16);
      p.ay1 = p.by0 + 24'($signed($urandom_range(span / 8)) - span / 16);
      p.bx1 = p.ax0;
      p.by1 = p.ay0;
    end else begin
      p.ax1 = rnd_coord(span); p.ay1 = rnd_coord(span);
      p.bx1 = rnd_coord(span); p.by1 = rnd_coord(span);
    end
    if ($urandom_range(9) == 0) begin
      p.ax1 = p.ax0 + p.bx1 - p.bx0;  // no relative motion
      p.ay1 = p.ay0 + p.by1 - p.by0;
    end
    p.ra = $urandom_range(3) == 0 ? 23'($urandom) : 23'($urandom_range(span / 4));
    p.rb = $urandom_range(3) == 0 ? 23'($urandom) : 23'($urandom_range(span / 4));
    return p;
  endfunction

  function automatic disc_pair_t make_pair(int ax0, int ay0, int ax1, int ay1, int ra,
                                           int bx0, int by0, int bx1, int by1, int rb);
    disc_pair_t p;
    p.ax0 = 24'(ax0); p.ay0 = 24'(ay0); p.ax1 = 24'(ax1); p.ay1 = 24'(ay1);
    p.ra = 23'(ra);
    p.bx0 = 24'(bx0); p.by0 = 24'(by0); p.bx1 = 24'(bx1); p.by1 = 24'(by1);
    p.rb = 23'(rb);
    return p;
  endfunction

  initial begin
    localparam int Max = 8388607, Min = -8388608, RMax = 8388607;
    repeat (12) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    quiet_stretch = 1;
    // Still pairs: overlapping, touching exactly, apart, and two zero discs at one point.
    send_pair(make_pair(0, 0, 0, 0, 4096, 100, 0, 100, 0, 4096));
    send_pair(make_pair(0, 0, 0, 0, 4096, 8192, 0, 8192, 0, 4096));
    send_pair(make_pair(0, 0, 0, 0, 4096, 8193, 0, 8193, 0, 4096));
    send_pair(make_pair(0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    // Head-on approach, contact before half way; crossing at the very end.
    send_pair(make_pair(0, 0, 40960, 0, 4096, 40960, 0, 0, 4096, 4096));
    send_pair(make_pair(0, 0, 8192, 0, 0, 16384, 0, 8192, 0, 0));
    // Contact ahead of the step, behind it, and no real root (passing wide).
    send_pair(make_pair(0, 0, 4096, 0, 0, 40960, 0, 40960, 0, 0));
    send_pair(make_pair(8192, 0, 16384, 0, 0, 0, 0, 0, 0, 100));
    send_pair(make_pair(0, 0, 40960, 0, 10, 20480, 40960, 20480, 40960, 10));
    // Overlap at the start while moving: time clamps to 0.
    send_pair(make_pair(0, 0, 4096, 0, 8192, 100, 0, 100, 0, 8192));
    // Field extremes.
    send_pair(make_pair(Min, Min, Max, Max, RMax, Max, Max, Min, Min, RMax));
    send_pair(make_pair(Max, Min, Min, Max, 0, Min, Max, Max, Min, 0));
    send_pair(make_pair(Min, Min, Min, Min, RMax, Max, Max, Max, Max, RMax));
    send_pair(make_pair(Max, Max, Max, Max, 0, Max, Max, Max, Max, 0));
    send_pair(make_pair(-1, -1, -1, -1, RMax, -1, -1, -1, -1, RMax));
    send_pair(make_pair(Min, 0, Max, 0, 1, Max, 0, Min, 0, 1));
    quiet_stretch = 0;
    drain();

    for (int i = 0; i < RandomPairs; i++) begin
      quiet_stretch = (i >= 600 && i < 900);
      send_pair(random_pair());
      if (i == 1200) drain();
    end
    drain();
    repeat (Latency + 5) @(posedge clk);

    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule

// ===== files.f =====
rtl/ddtoi_pkg.sv
rtl/ddtoi_cell.sv
rtl/ddtoi_setup.sv
rtl/disc_disc_time_of_impact_core.sv
rtl/ddtoi_checker.sv
test/tb_disc_disc_time_of_impact_core.sv
